@@ sv/uet_pkg.sv @@
// Shared types and constants for the unique edge table.
// Used by uet_cell, uet_out_stage and unique_edge_table_core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package uet_pkg;

    localparam int EDGE_COUNT_BITS = 11;

    typedef logic [EDGE_COUNT_BITS-1:0] edge_count_t;

    typedef struct packed {
        logic valid;
        logic found;
        logic inserted;
    } probe_flags_t;

endpackage

`default_nettype wire

@@ sv/uet_cell.sv @@
// One cell of the edge chain: holds one stored edge and one stage of the probe pipeline.
// Depends on uet_pkg for the probe flag struct.
`timescale 1ns / 1ps
`default_nettype none

module uet_cell #(
    parameter int VIDX_BITS = 16,
    parameter int CNT_BITS = 11,
    parameter logic [CNT_BITS-1:0] CELL_INDEX = '0
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    adv,
    input  wire logic [CNT_BITS-1:0]     count,
    input  wire uet_pkg::probe_flags_t   flags_prev,
    input  wire logic [VIDX_BITS-1:0]    a_prev,
    input  wire logic [VIDX_BITS-1:0]    b_prev,
    output uet_pkg::probe_flags_t        flags,
    output logic [VIDX_BITS-1:0]         a,
    output logic [VIDX_BITS-1:0]         b,
    output logic                         take
);

    logic [VIDX_BITS-1:0]  entry_a_reg;
    logic [VIDX_BITS-1:0]  entry_b_reg;
    uet_pkg::probe_flags_t flags_reg;
    uet_pkg::probe_flags_t flags_next;
    logic [VIDX_BITS-1:0]  a_reg;
    logic [VIDX_BITS-1:0]  b_reg;
    logic                  occupied;
    logic                  is_tail;
    logic                  pending;
    logic                  same;
    logic                  match;

    // Entries below the fill count are valid, and the entry at the fill count is the next free one.
    assign occupied = (CELL_INDEX < count);
    assign is_tail  = (CELL_INDEX == count);
    assign pending  = flags_prev.valid && !flags_prev.found && !flags_prev.inserted;
    assign same     = ((a_prev == entry_a_reg) && (b_prev == entry_b_reg)) ||
                      ((a_prev == entry_b_reg) && (b_prev == entry_a_reg));
    assign match    = pending && occupied && same;
    assign take     = pending && is_tail;

    always_comb
    begin
        flags_next.valid    = flags_prev.valid;
        flags_next.found    = flags_prev.found || match;
        flags_next.inserted = flags_prev.inserted || take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (adv)
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= a_prev;
            b_reg <= b_prev;
            if (take)
            begin
                entry_a_reg <= a_prev;
                entry_b_reg <= b_prev;
            end
        end
    end

    assign flags = flags_reg;
    assign a     = a_reg;
    assign b     = b_reg;

endmodule

`default_nettype wire

@@ sv/uet_out_stage.sv @@
// Result register at the end of the edge chain, with the running count of delivered inserts.
// Depends on uet_pkg for the probe flag struct and the edge count type.
`timescale 1ns / 1ps
`default_nettype none

module uet_out_stage #(
    parameter int CNT_BITS = 11
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire uet_pkg::probe_flags_t flags_last,
    input  wire logic                  result_ready,
    output logic                       adv,
    output logic                       result_valid,
    output logic                       is_new,
    output uet_pkg::edge_count_t       edge_count,
    output logic                       table_full
);

    logic                 valid_reg;
    logic                 is_new_reg;
    logic                 table_full_reg;
    uet_pkg::edge_count_t edge_count_reg;
    logic [CNT_BITS-1:0]  out_cnt_reg;
    logic [CNT_BITS-1:0]  out_cnt_next;

    assign adv          = !valid_reg || result_ready;
    assign out_cnt_next = out_cnt_reg + CNT_BITS'(flags_last.inserted);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            out_cnt_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= flags_last.valid;
            if (flags_last.valid)
            begin
                out_cnt_reg <= out_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && flags_last.valid)
        begin
            is_new_reg     <= !flags_last.found;
            table_full_reg <= !flags_last.found && !flags_last.inserted;
            edge_count_reg <= uet_pkg::edge_count_t'(out_cnt_next);
        end
    end

    assign result_valid = valid_reg;
    assign is_new       = is_new_reg;
    assign table_full   = table_full_reg;
    assign edge_count   = edge_count_reg;

endmodule

`default_nettype wire

@@ sv/unique_edge_table_core.sv @@
// Top level of the unique edge table: a chain of MAX_EDGES cells and a result register.
// Depends on uet_pkg, uet_cell and uet_out_stage.
//
//   Channel   Handshake                    Payload
//   edge      edge_valid / edge_ready      vertex_a, vertex_b
//   result    result_valid / result_ready  is_new, edge_count, table_full
//
// Each transaction walks the cell chain one cell per cycle while the chain advances, and then
// enters the result register; one edge is taken every cycle unless the chain is stalled.
// The shared fill count lets each cell tell used from free.
// Reset clears the fill count and the pipeline valid flags; stored edges are not cleared.
// When result_ready is low with a result waiting, the whole chain holds its place.
`timescale 1ns / 1ps
`default_nettype none

module unique_edge_table_core #(
    parameter int MAX_EDGES = 1024,
    parameter int VERTEX_INDEX_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          edge_valid,
    output logic                               edge_ready,
    input  wire logic [VERTEX_INDEX_BITS-1:0]  vertex_a,
    input  wire logic [VERTEX_INDEX_BITS-1:0]  vertex_b,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic                               is_new,
    output uet_pkg::edge_count_t               edge_count,
    output logic                               table_full
);

    localparam int CNT_BITS = $clog2(MAX_EDGES + 1);

    uet_pkg::probe_flags_t         flags_chain [MAX_EDGES];
    logic [VERTEX_INDEX_BITS-1:0]  a_chain [MAX_EDGES];
    logic [VERTEX_INDEX_BITS-1:0]  b_chain [MAX_EDGES];
    logic [MAX_EDGES-1:0]          take_vec;
    uet_pkg::probe_flags_t         flags_head;
    logic [CNT_BITS-1:0]           count_reg;
    logic [CNT_BITS-1:0]           count_next;
    logic                          adv;

    assign flags_head.valid    = edge_valid;
    assign flags_head.found    = 1'b0;
    assign flags_head.inserted = 1'b0;
    assign edge_ready          = adv;

    // At most one cell sits at the tail, so any take means one new stored edge.
    assign count_next = count_reg + CNT_BITS'(|take_vec);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (adv)
        begin
            count_reg <= count_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < MAX_EDGES; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                uet_cell #(
                    .VIDX_BITS  (VERTEX_INDEX_BITS),
                    .CNT_BITS   (CNT_BITS),
                    .CELL_INDEX (CNT_BITS'(i))
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .adv        (adv),
                    .count      (count_reg),
                    .flags_prev (flags_head),
                    .a_prev     (vertex_a),
                    .b_prev     (vertex_b),
                    .flags      (flags_chain[i]),
                    .a          (a_chain[i]),
                    .b          (b_chain[i]),
                    .take       (take_vec[i])
                );
            end
            else
            begin : g_body
                uet_cell #(
                    .VIDX_BITS  (VERTEX_INDEX_BITS),
                    .CNT_BITS   (CNT_BITS),
                    .CELL_INDEX (CNT_BITS'(i))
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .adv        (adv),
                    .count      (count_reg),
                    .flags_prev (flags_chain[i-1]),
                    .a_prev     (a_chain[i-1]),
                    .b_prev     (b_chain[i-1]),
                    .flags      (flags_chain[i]),
                    .a          (a_chain[i]),
                    .b          (b_chain[i]),
                    .take       (take_vec[i])
                );
            end
        end
    endgenerate

    uet_out_stage #(
        .CNT_BITS (CNT_BITS)
    ) u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .flags_last   (flags_chain[MAX_EDGES-1]),
        .result_ready (result_ready),
        .adv          (adv),
        .result_valid (result_valid),
        .is_new       (is_new),
        .edge_count   (edge_count),
        .table_full   (table_full)
    );

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(MAX_EDGES))
        else $error("Fill count exceeds table size.");

    a_single_take: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(take_vec))
        else $error("More than one cell stored an edge in the same cycle.");

    a_count_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(count_reg))
        else $error("Fill count changed while the chain was stalled.");

    a_full_implies_new: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && table_full |-> is_new)
        else $error("Dropped edge reported as a duplicate.");
`endif

endmodule

`default_nettype wire

@@ tb/sv/unique_edge_table_core_test.sv @@
// Self-checking testbench for unique_edge_table_core: directed edge probes, then random
// fills of the edge table up to and past full, checked against an in-bench edge-set model.
// Depends on uet_pkg and the RTL of unique_edge_table_core.
`timescale 1ns / 1ps

module unique_edge_table_core_test;

    localparam int MAX_EDGES = 1024;
    localparam int VERTEX_BITS = 16;
    localparam int PROBE_COUNT = 21;

    typedef logic [VERTEX_BITS-1:0] vertex_t;

    typedef struct packed {
        logic                 is_new;
        uet_pkg::edge_count_t edge_count;
        logic                 table_full;
    } edge_result_t;

    typedef struct packed {
        vertex_t              a;
        vertex_t              b;
        logic                 typed;
        logic                 exp_new;
        uet_pkg::edge_count_t exp_count;
        logic                 exp_full;
    } probe_row_t;

    localparam probe_row_t PROBE_ROWS [0:PROBE_COUNT-1] = '{
        '{16'h0000, 16'h0000, 1'b1, 1'b1, 11'd1, 1'b0},
        '{16'h0000, 16'h0000, 1'b1, 1'b0, 11'd1, 1'b0},
        '{16'hFFFF, 16'h0000, 1'b1, 1'b1, 11'd2, 1'b0},
        '{16'h0000, 16'hFFFF, 1'b1, 1'b0, 11'd2, 1'b0},
        '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 11'd3, 1'b0},
        '{16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 11'd3, 1'b0},
        '{16'h0001, 16'h0002, 1'b1, 1'b1, 11'd4, 1'b0},
        '{16'h0002, 16'h0001, 1'b1, 1'b0, 11'd4, 1'b0},
        '{16'hAAAA, 16'h5555, 1'b1, 1'b1, 11'd5, 1'b0},
        '{16'h5555, 16'hAAAA, 1'b1, 1'b0, 11'd5, 1'b0},
        '{16'h5555, 16'h5555, 1'b1, 1'b1, 11'd6, 1'b0},
        '{16'h8000, 16'h7FFF, 1'b0, 1'b0, 11'd0, 1'b0},
        '{16'h7FFF, 16'h8000, 1'b0, 1'b0, 11'd0, 1'b0},
        '{16'h0001, 16'h0001, 1'b0, 1'b0, 11'd0, 1'b0},
        '{16'h0002, 16'h0001, 1'b0, 1'b0, 11'd0, 1'b0},
        '{16'hFFFF, 16'h0001, 1'b0, 1'b0, 11'd0, 1'b0},
        '{16'h0001, 16'hFFFF, 1'b0, 1'b0, 11'd0, 1'b0},
        '{16'h0000, 16'hFFFF, 1'b0, 1'b0, 11'd0, 1'b0},
        '{16'h1234, 16'hABCD, 1'b0, 1'b0, 11'd0, 1'b0},
        '{16'hABCD, 16'h1234, 1'b0, 1'b0, 11'd0, 1'b0},
        '{16'h1234, 16'h1234, 1'b0, 1'b0, 11'd0, 1'b0}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 edge_valid;
    logic                 edge_ready;
    vertex_t              vertex_a;
    vertex_t              vertex_b;
    logic                 result_valid;
    logic                 result_ready;
    logic                 is_new;
    uet_pkg::edge_count_t edge_count;
    logic                 table_full;

    vertex_t      known_a [MAX_EDGES];
    vertex_t      known_b [MAX_EDGES];
    int           known_count;
    edge_result_t pending_results [$];
    int           errors;
    bit           quiet;
    bit           sender_idle_on;
    bit           receiver_idle_on;

    unique_edge_table_core #(
        .MAX_EDGES(MAX_EDGES),
        .VERTEX_INDEX_BITS(VERTEX_BITS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .edge_valid(edge_valid),
        .edge_ready(edge_ready),
        .vertex_a(vertex_a),
        .vertex_b(vertex_b),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .is_new(is_new),
        .edge_count(edge_count),
        .table_full(table_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic edge_result_t dedup_edge(input vertex_t a, input vertex_t b);
        edge_result_t res;
        bit           found;
        found = 1'b0;
        for (int i = 0; i < known_count; i++)
        begin
            if ((known_a[i] == a && known_b[i] == b) || (known_a[i] == b && known_b[i] == a))
            begin
                found = 1'b1;
                break;
            end
        end
        res.table_full = 1'b0;
        if (!found)
        begin
            if (known_count < MAX_EDGES)
            begin
                known_a[known_count] = a;
                known_b[known_count] = b;
                known_count++;
            end
            else
            begin
                res.table_full = 1'b1;
            end
        end
        res.is_new = !found;
        res.edge_count = uet_pkg::edge_count_t'(known_count);
        return res;
    endfunction

    function automatic vertex_t pick_vertex();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else
            return vertex_t'($urandom_range(0, 65535));
    endfunction

    task automatic sender_gap();
        if (!quiet && sender_idle_on && $urandom_range(0, 3) == 0)
        begin
            edge_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic send_edge(input vertex_t a, input vertex_t b, input bit typed,
                             input edge_result_t typed_result);
        edge_result_t predicted;
        edge_valid <= 1'b1;
        vertex_a <= a;
        vertex_b <= b;
        do
            @(posedge clk);
        while (!edge_ready);
        predicted = dedup_edge(a, b);
        pending_results.insert(pending_results.size(), typed ? typed_result : predicted);
    endtask

    task automatic drain_results();
        edge_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_edge(input int dup_pct, output vertex_t a, output vertex_t b);
        int r;
        int idx;
        r = $urandom_range(0, 99);
        if (r < dup_pct && known_count > 0)
        begin
            idx = $urandom_range(0, known_count - 1);
            if ($urandom_range(0, 1) == 1)
            begin
                a = known_b[idx];
                b = known_a[idx];
            end
            else
            begin
                a = known_a[idx];
                b = known_b[idx];
            end
        end
        else if (r < dup_pct + 4)
        begin
            a = vertex_t'($urandom_range(0, 7));
            b = vertex_t'($urandom_range(0, 7));
        end
        else
        begin
            a = pick_vertex();
            b = pick_vertex();
        end
    endtask

    initial
    begin
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!quiet && receiver_idle_on && $urandom_range(0, 3) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            result_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            receiver_idle_on = ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        edge_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with no expectation pending");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (is_new !== want.is_new)
                begin
                    $error("is_new: expected %0d, actual %0d", want.is_new, is_new);
                    errors++;
                end
                if (edge_count !== want.edge_count)
                begin
                    $error("edge_count: expected %0d, actual %0d", want.edge_count, edge_count);
                    errors++;
                end
                if (table_full !== want.table_full)
                begin
                    $error("table_full: expected %0d, actual %0d", want.table_full, table_full);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        edge_result_t typed_result;
        vertex_t      a;
        vertex_t      b;
        int           issued;
        edge_valid = 1'b0;
        vertex_a = '0;
        vertex_b = '0;
        rst_n = 1'b0;
        errors = 0;
        known_count = 0;
        quiet = 1'b0;
        sender_idle_on = 1'b1;
        receiver_idle_on = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PROBE_COUNT; i++)
        begin
            typed_result.is_new = PROBE_ROWS[i].exp_new;
            typed_result.edge_count = PROBE_ROWS[i].exp_count;
            typed_result.table_full = PROBE_ROWS[i].exp_full;
            sender_gap();
            send_edge(PROBE_ROWS[i].a, PROBE_ROWS[i].b, PROBE_ROWS[i].typed, typed_result);
        end
        drain_results();

        // Fill the table: mostly fresh edges, with repeats in both directions.
        issued = 0;
        while (known_count < MAX_EDGES)
        begin
            issued++;
            if (issued % 48 == 0)
                sender_idle_on = ($urandom_range(0, 2) != 0);
            if (issued == 400)
                drain_results();
            random_edge(8, a, b);
            sender_gap();
            send_edge(a, b, 1'b0, '0);
        end

        // With the table full, new edges are dropped and repeats still match.
        for (int i = 0; i < 72; i++)
        begin
            if (i == 32)
                quiet = 1'b1;
            random_edge(50, a, b);
            sender_gap();
            send_edge(a, b, 1'b0, '0);
        end
        edge_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (MAX_EDGES + 64) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/uet_pkg.sv
sv/uet_cell.sv
sv/uet_out_stage.sv
sv/unique_edge_table_core.sv
tb/sv/unique_edge_table_core_test.sv
